/* rtl/cmf_pkg.sv */
// Shared constants, codes and stage types of the cube map face selector.
package cmf_pkg;

	// Input coordinate width (signed Q1.(COORD_WIDTH-1)) and output fraction width.
	localparam int COORD_WIDTH = 16;
	localparam int UV_WIDTH    = 16;

	typedef logic [2:0] face_t;

	localparam face_t FACE_POS_X = 3'd0;
	localparam face_t FACE_NEG_X = 3'd1;
	localparam face_t FACE_POS_Y = 3'd2;
	localparam face_t FACE_NEG_Y = 3'd3;
	localparam face_t FACE_POS_Z = 3'd4;
	localparam face_t FACE_NEG_Z = 3'd5;

	typedef logic [COORD_WIDTH-1:0] mag_t;
	typedef logic [UV_WIDTH-1:0]    frac_t;

	// Item as it travels down the divider chain.
	typedef struct packed {
		face_t face;
		logic  zero;
		logic  sat_u;
		logic  sat_v;
		mag_t  mag;
		mag_t  rem_u;
		mag_t  rem_v;
		frac_t quo_u;
		frac_t quo_v;
	} div_t;

endpackage

/* rtl/cmf_if.sv */
// Valid/ready channels for direction items and face coordinate items.
interface cmf_vec_if;
	import cmf_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;

	modport source(output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink(input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmf_uv_if;
	import cmf_pkg::*;

	logic       valid;
	logic       ready;
	face_t      face;
	frac_t      tex_u;
	frac_t      tex_v;
	logic       zero_vector;

	modport source(output valid, output face, output tex_u, output tex_v,
		output zero_vector, input ready);
	modport sink(input valid, input face, input tex_u, input tex_v,
		input zero_vector, output ready);
endinterface

/* rtl/cmf_select.sv */
// Face selection stage: picks the major axis and sets up the two divisions.
module cmf_select (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  logic signed [cmf_pkg::COORD_WIDTH-1:0] dir_x,
	input  logic signed [cmf_pkg::COORD_WIDTH-1:0] dir_y,
	input  logic signed [cmf_pkg::COORD_WIDTH-1:0] dir_z,
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output cmf_pkg::div_t                          dn_data
);
	import cmf_pkg::*;

	typedef logic signed [COORD_WIDTH:0] wide_t;

	mag_t  ax, ay, az, mag;
	wide_t ex, ey, ez, uc, vc, mag_ext, ru_full, rv_full;
	face_t face;
	logic  zero, pos_u, pos_v, sat_u, sat_v;
	logic  valid_s1;
	div_t  data_s1;

	// Sign-extend by one bit so that the negation of the most negative value is exact.
	assign ex = {dir_x[COORD_WIDTH-1], dir_x};
	assign ey = {dir_y[COORD_WIDTH-1], dir_y};
	assign ez = {dir_z[COORD_WIDTH-1], dir_z};

	// Magnitudes fit in COORD_WIDTH unsigned bits, including the most negative input.
	assign ax = dir_x[COORD_WIDTH-1] ? mag_t'(~dir_x + 1'b1) : mag_t'(dir_x);
	assign ay = dir_y[COORD_WIDTH-1] ? mag_t'(~dir_y + 1'b1) : mag_t'(dir_y);
	assign az = dir_z[COORD_WIDTH-1] ? mag_t'(~dir_z + 1'b1) : mag_t'(dir_z);

	assign zero = (ax == '0) && (ay == '0) && (az == '0);

	// Major axis: Z wins ties over Y, Y wins ties over X; zero counts as negative.
	always_comb begin
		if (az >= ax && az >= ay) begin
			mag = az;
			if (!dir_z[COORD_WIDTH-1] && dir_z != '0) begin
				face = FACE_POS_Z; uc = ex;  vc = ey;
			end else begin
				face = FACE_NEG_Z; uc = -ex; vc = ey;
			end
		end else if (ay >= ax) begin
			mag = ay;
			if (!dir_y[COORD_WIDTH-1] && dir_y != '0) begin
				face = FACE_POS_Y; uc = ex; vc = -ez;
			end else begin
				face = FACE_NEG_Y; uc = ex; vc = ez;
			end
		end else begin
			mag = ax;
			if (!dir_x[COORD_WIDTH-1] && dir_x != '0) begin
				face = FACE_POS_X; uc = -ez; vc = ey;
			end else begin
				face = FACE_NEG_X; uc = ez;  vc = ey;
			end
		end
	end

	// Leading quotient digit of (c + max) / max and its remainder, found by sign alone.
	assign mag_ext = wide_t'({1'b0, mag});
	assign sat_u   = (uc == mag_ext);
	assign sat_v   = (vc == mag_ext);
	assign pos_u   = !uc[COORD_WIDTH];
	assign pos_v   = !vc[COORD_WIDTH];
	assign ru_full = pos_u ? uc : uc + mag_ext;
	assign rv_full = pos_v ? vc : vc + mag_ext;

	assign up_ready = !valid_s1 || dn_ready;

	// Stage register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// Stage register payload.
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1.face  <= face;
			data_s1.zero  <= zero;
			data_s1.sat_u <= sat_u;
			data_s1.sat_v <= sat_v;
			data_s1.mag   <= mag;
			data_s1.rem_u <= sat_u ? '0 : ru_full[COORD_WIDTH-1:0];
			data_s1.rem_v <= sat_v ? '0 : rv_full[COORD_WIDTH-1:0];
			data_s1.quo_u <= {{(UV_WIDTH-1){1'b0}}, pos_u};
			data_s1.quo_v <= {{(UV_WIDTH-1){1'b0}}, pos_v};
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;
endmodule

/* rtl/cmf_cell.sv */
// Divider cell: one restoring step for both coordinates, then a stage register.
module cmf_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  cmf_pkg::div_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output cmf_pkg::div_t dn_data
);
	import cmf_pkg::*;

	logic [COORD_WIDTH:0] dbl_u, dbl_v, mag_ext;
	logic [COORD_WIDTH:0] sub_u, sub_v;
	logic                 bit_u, bit_v;
	logic                 valid_q;
	div_t                 nxt_data;
	div_t                 data_q;

	// Remainder is below the divisor, so its double fits in COORD_WIDTH+1 bits.
	assign dbl_u   = {up_data.rem_u, 1'b0};
	assign dbl_v   = {up_data.rem_v, 1'b0};
	assign mag_ext = {1'b0, up_data.mag};
	assign bit_u   = dbl_u >= mag_ext;
	assign bit_v   = dbl_v >= mag_ext;
	assign sub_u   = dbl_u - mag_ext;
	assign sub_v   = dbl_v - mag_ext;

	// Next item: new remainders and the quotient bits shifted in.
	always_comb begin
		nxt_data       = up_data;
		nxt_data.rem_u = bit_u ? sub_u[COORD_WIDTH-1:0] : dbl_u[COORD_WIDTH-1:0];
		nxt_data.rem_v = bit_v ? sub_v[COORD_WIDTH-1:0] : dbl_v[COORD_WIDTH-1:0];
		nxt_data.quo_u = {up_data.quo_u[UV_WIDTH-2:0], bit_u};
		nxt_data.quo_v = {up_data.quo_v[UV_WIDTH-2:0], bit_v};
	end

	assign up_ready = !valid_q || dn_ready;

	// Cell register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Cell register payload.
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt_data;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
endmodule

/* rtl/cmf_pack.sv */
// Output stage: saturates full-scale values, clears the zero vector case, registers the item.
module cmf_pack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  cmf_pkg::div_t up_data,
	cmf_uv_if.source      res
);
	import cmf_pkg::*;

	logic  valid_q;
	face_t face_q;
	frac_t u_q, v_q;
	logic  zero_q;
	frac_t u_val, v_val;

	// A coordinate equal to the axis magnitude maps to the largest fraction.
	assign u_val = up_data.zero ? '0 : (up_data.sat_u ? '1 : up_data.quo_u);
	assign v_val = up_data.zero ? '0 : (up_data.sat_v ? '1 : up_data.quo_v);

	assign up_ready = !valid_q || res.ready;

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			face_q <= up_data.face;
			u_q    <= u_val;
			v_q    <= v_val;
			zero_q <= up_data.zero;
		end
	end

	assign res.valid       = valid_q;
	assign res.face        = face_q;
	assign res.tex_u       = u_q;
	assign res.tex_v       = v_q;
	assign res.zero_vector = zero_q;
endmodule

/* rtl/cube_map_face_uv_from_direction.sv */
// Top level of the cube map face selector with face-local texture coordinates.
// A direction item enters on vec and leaves on res as a face code and two 0.16
// fractions. The block takes one item every cycle while res does not stall it.
// The select stage picks the face, UV_WIDTH-1 divider cells each add one
// quotient bit to both coordinates, and one output register finishes the
// result. Each stage stalls only when the stage after it is full, so bubbles
// close up while the output waits.
module cube_map_face_uv_from_direction (
	input  logic     clk,
	input  logic     arst_n,
	cmf_vec_if.sink  vec,
	cmf_uv_if.source res
);
	import cmf_pkg::*;

	localparam int NUM_CELLS = UV_WIDTH - 1;

	div_t st_data  [NUM_CELLS+1];
	logic st_valid [NUM_CELLS+1];
	logic st_ready [NUM_CELLS+1];

	// Face selection and setup of the leading quotient digit.
	cmf_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vec.valid),
		.up_ready (vec.ready),
		.dir_x    (vec.dir_x),
		.dir_y    (vec.dir_y),
		.dir_z    (vec.dir_z),
		.dn_valid (st_valid[0]),
		.dn_ready (st_ready[0]),
		.dn_data  (st_data[0])
	);

	// Chain of divider cells, one quotient bit each.
	for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
		cmf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (st_valid[k-1]),
			.up_ready (st_ready[k-1]),
			.up_data  (st_data[k-1]),
			.dn_valid (st_valid[k]),
			.dn_ready (st_ready[k]),
			.dn_data  (st_data[k])
		);
	end

	// Final saturation and output register.
	cmf_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (st_valid[NUM_CELLS]),
		.up_ready (st_ready[NUM_CELLS]),
		.up_data  (st_data[NUM_CELLS]),
		.res      (res)
	);
endmodule
